/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/hrv_pkg.sv */
// Package: phases, roles, keyword tables and character classes for the request validator
`default_nettype none
package hrv_pkg;
  typedef enum logic [3:0] {
    PH_METHOD, PH_TARGET_FIRST, PH_TARGET, PH_VERSION,
    PH_LINE_START, PH_NAME, PH_VALUE, PH_SKIP
  } phase_t;

  localparam logic [2:0] NUM_LEAD  = 3'd0;
  localparam logic [2:0] NUM_SIGN  = 3'd1;
  localparam logic [2:0] NUM_ZEROS = 3'd2;
  localparam logic [2:0] NUM_TRAIL = 3'd3;
  localparam logic [2:0] NUM_BAD   = 3'd4;

  localparam logic [1:0] ROLE_METHOD = 2'd0;
  localparam logic [1:0] ROLE_TARGET = 2'd1;
  localparam logic [1:0] ROLE_TEXT   = 2'd2;
  localparam logic [1:0] ROLE_BREAK  = 2'd3;

  localparam logic [1:0] CONN_NONE  = 2'd0;
  localparam logic [1:0] CONN_CLOSE = 2'd1;
  localparam logic [1:0] CONN_KEEP  = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] pos;
    logic [1:0] name_c;
    logic [2:0] val_c;
    logic       cr;
    logic       sp;
    logic       seen_conn;
    logic       seen_clen;
    logic [1:0] conn_val;
    logic       err;
  } pstate_t;

  typedef struct packed {
    logic [7:0] echo;
    logic [1:0] role;
    logic       done;
    logic       bad;
    logic [1:0] conn;
    logic       failed;
  } result_t;

  localparam pstate_t PSTATE_RESET = '{phase: PH_METHOD, pos: 4'd0, name_c: 2'd3,
    val_c: 3'd7, cr: 1'b0, sp: 1'b0, seen_conn: 1'b0, seen_clen: 1'b0,
    conn_val: CONN_NONE, err: 1'b0};

  function automatic logic [7:0] ver_ch(input logic [3:0] p);
    case (p)
      4'd0: ver_ch = "H"; 4'd1: ver_ch = "T"; 4'd2: ver_ch = "T"; 4'd3: ver_ch = "P";
      4'd4: ver_ch = "/"; 4'd5: ver_ch = "1"; 4'd6: ver_ch = "."; 4'd7: ver_ch = "1";
      default: ver_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] conn_ch(input logic [3:0] p);
    case (p)
      4'd0: conn_ch = "c"; 4'd1: conn_ch = "o"; 4'd2: conn_ch = "n"; 4'd3: conn_ch = "n";
      4'd4: conn_ch = "e"; 4'd5: conn_ch = "c"; 4'd6: conn_ch = "t"; 4'd7: conn_ch = "i";
      4'd8: conn_ch = "o"; 4'd9: conn_ch = "n";
      default: conn_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] clen_ch(input logic [3:0] p);
    case (p)
      4'd0: clen_ch = "c"; 4'd1: clen_ch = "o"; 4'd2: clen_ch = "n"; 4'd3: clen_ch = "t";
      4'd4: clen_ch = "e"; 4'd5: clen_ch = "n"; 4'd6: clen_ch = "t"; 4'd7: clen_ch = "-";
      4'd8: clen_ch = "l"; 4'd9: clen_ch = "e"; 4'd10: clen_ch = "n"; 4'd11: clen_ch = "g";
      4'd12: clen_ch = "t"; 4'd13: clen_ch = "h";
      default: clen_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] close_ch(input logic [3:0] p);
    case (p)
      4'd0: close_ch = "c"; 4'd1: close_ch = "l"; 4'd2: close_ch = "o";
      4'd3: close_ch = "s"; 4'd4: close_ch = "e";
      default: close_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] keep_ch(input logic [3:0] p);
    case (p)
      4'd0: keep_ch = "k"; 4'd1: keep_ch = "e"; 4'd2: keep_ch = "e"; 4'd3: keep_ch = "p";
      4'd4: keep_ch = "-"; 4'd5: keep_ch = "a"; 4'd6: keep_ch = "l"; 4'd7: keep_ch = "i";
      4'd8: keep_ch = "v"; 4'd9: keep_ch = "e";
      default: keep_ch = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic name_ok(input logic [7:0] c);
    name_ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
              (c >= "0" && c <= "9") || c == "_" || c == "-";
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = c == CH_SP || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [3:0] bump(input logic [3:0] p);
    bump = (p == 4'd15) ? p : p + 4'd1;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/hrv_parse.sv */
// Combinational next-state logic: one byte through the parser
`default_nettype none
module hrv_parse (
  input  wire logic [7:0]       c,
  input  wire hrv_pkg::pstate_t st,
  input  wire logic             failed,
  output hrv_pkg::pstate_t      st_nxt,
  output hrv_pkg::result_t      res,
  output logic                  failed_nxt
);
  import hrv_pkg::*;

  function automatic pstate_t feed(input pstate_t s, input logic [7:0] ch);
    pstate_t    n;
    logic [7:0] f;
    logic [1:0] kind;
    n = s;
    f = fold(ch);
    kind = 2'd0;
    unique case (s.phase)
      PH_METHOD: if (ch == CH_SP) n.phase = PH_TARGET_FIRST;
      PH_TARGET_FIRST: begin
        if (ch == CH_SP) begin
          n.err = 1'b1; n.phase = PH_VERSION; n.pos = 4'd0;
        end else begin
          if (ch != "/") n.err = 1'b1;
          n.phase = PH_TARGET;
        end
      end
      PH_TARGET: if (ch == CH_SP) begin
        n.phase = PH_VERSION; n.pos = 4'd0;
      end
      PH_VERSION: begin
        if (s.pos >= 4'd8 || ver_ch(s.pos) != ch) n.err = 1'b1;
        n.pos = bump(s.pos);
      end
      PH_LINE_START, PH_NAME: begin
        if (s.phase == PH_LINE_START) begin
          n.phase = PH_NAME; n.name_c = 2'd3; n.pos = 4'd0;
        end
        if (ch == ":") begin
          if (n.pos == 4'd0) begin
            n.err = 1'b1; n.phase = PH_SKIP;
          end else begin
            if (n.name_c[0] && n.pos == 4'd10) kind = 2'd1;
            else if (n.name_c[1] && n.pos == 4'd14) kind = 2'd2;
            if (kind == 2'd0) n.phase = PH_SKIP;
            else begin
              if (kind == 2'd1) begin
                if (n.seen_conn) n.err = 1'b1;
                n.seen_conn = 1'b1;
              end else begin
                if (n.seen_clen) n.err = 1'b1;
                n.seen_clen = 1'b1;
              end
              n.name_c = kind; n.phase = PH_VALUE; n.pos = 4'd0; n.sp = 1'b0;
              n.val_c = (kind == 2'd1) ? 3'd3 : NUM_LEAD;
            end
          end
        end else if (!name_ok(f)) begin
          n.err = 1'b1; n.phase = PH_SKIP;
        end else begin
          if (n.pos >= 4'd10 || conn_ch(n.pos) != f) n.name_c[0] = 1'b0;
          if (n.pos >= 4'd14 || clen_ch(n.pos) != f) n.name_c[1] = 1'b0;
          n.pos = bump(n.pos);
        end
      end
      PH_VALUE: begin
        if (s.name_c == 2'd1) begin
          if (f == CH_SP) begin
            if (s.pos != 4'd0) n.sp = 1'b1;
          end else if (s.sp) n.val_c = 3'd0;
          else begin
            if (s.pos >= 4'd5 || close_ch(s.pos) != f) n.val_c[0] = 1'b0;
            if (s.pos >= 4'd10 || keep_ch(s.pos) != f) n.val_c[1] = 1'b0;
            n.val_c[2] = 1'b0;
            n.val_c = n.val_c & s.val_c;
            n.pos = bump(s.pos);
          end
        end else begin
          case (s.val_c)
            NUM_LEAD: if (!is_ws(f)) begin
              if (f == "+" || f == "-") n.val_c = NUM_SIGN;
              else n.val_c = (f == "0") ? NUM_ZEROS : NUM_BAD;
            end
            NUM_SIGN: n.val_c = (f == "0") ? NUM_ZEROS : NUM_BAD;
            NUM_ZEROS: begin
              if (f == CH_SP) n.val_c = NUM_TRAIL;
              else if (f != "0") n.val_c = NUM_BAD;
            end
            NUM_TRAIL: if (f != CH_SP) n.val_c = NUM_BAD;
            default: n.val_c = NUM_BAD;
          endcase
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  pstate_t s1;
  pstate_t le;
  logic    empty_line;

  always_comb begin
    le = st;
    empty_line = 1'b0;
    unique case (st.phase)
      PH_LINE_START: empty_line = 1'b1;
      PH_VERSION: if (st.pos != 4'd8) le.err = 1'b1;
      PH_VALUE: begin
        if (st.name_c == 2'd1) begin
          if (st.val_c[0] && st.pos == 4'd5) le.conn_val = CONN_CLOSE;
          else if (st.val_c[1] && st.pos == 4'd10) le.conn_val = CONN_KEEP;
          else le.err = 1'b1;
        end else if (st.val_c != NUM_ZEROS && st.val_c != NUM_TRAIL) le.err = 1'b1;
      end
      PH_SKIP: ;
      default: le.err = 1'b1;
    endcase
    le.phase = PH_LINE_START;
    le.cr = 1'b0;
  end

  always_comb begin
    s1 = st;
    if (st.cr && c != CH_LF) begin
      s1 = feed(st, CH_CR);
      if (c != CH_CR) s1.cr = 1'b0;
    end
  end

  always_comb begin
    st_nxt = st;
    failed_nxt = failed;
    res.echo = c;
    res.role = ROLE_TEXT;
    res.done = 1'b0;
    res.bad = 1'b0;
    res.conn = CONN_NONE;
    res.failed = failed;
    if (!failed) begin
      if (st.cr && c == CH_LF) begin
        res.role = ROLE_BREAK;
        if (empty_line) begin
          res.done = 1'b1;
          res.bad = st.err;
          res.conn = st.err ? CONN_NONE : st.conn_val;
          failed_nxt = st.err;
          st_nxt = PSTATE_RESET;
        end else st_nxt = le;
      end else if (c == CH_CR) begin
        res.role = ROLE_BREAK;
        st_nxt = s1;
        st_nxt.cr = 1'b1;
      end else begin
        if (s1.phase == PH_METHOD) res.role = ROLE_METHOD;
        else if (s1.phase == PH_TARGET_FIRST || s1.phase == PH_TARGET) res.role = ROLE_TARGET;
        st_nxt = feed(s1, c);
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/http_request_validator.sv */
// Top level: HTTP/1.1 request head validator
// Takes one byte per cycle while the output is not stalled and returns one
// result per byte, registered in the cycle after the byte is accepted: the parser
// state and the byte-to-result logic sit between the parser state register and a
// single output register, so a byte may be accepted on every cycle while the output is not stalled.
`default_nettype none
`include "assert_macros.svh"
module http_request_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_echo_byte,
  output logic [1:0]      out_byte_role,
  output logic            out_message_done,
  output logic            out_request_bad,
  output logic [1:0]      out_connection_kind,
  output logic            out_stream_failed
);
  import hrv_pkg::*;

  pstate_t st_r, st_nxt;
  logic    failed_r, failed_nxt;
  result_t res, res_r;
  logic    valid_r;
  logic    take;

  assign in_stall = valid_r && out_stall;
  assign take = in_valid && !in_stall;

  hrv_parse u_parse (
    .c(in_rx_byte), .st(st_r), .failed(failed_r),
    .st_nxt(st_nxt), .res(res), .failed_nxt(failed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PSTATE_RESET;
      failed_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (take) begin
        st_r <= st_nxt;
        failed_r <= failed_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_echo_byte = res_r.echo;
  assign out_byte_role = res_r.role;
  assign out_message_done = res_r.done;
  assign out_request_bad = res_r.bad;
  assign out_connection_kind = res_r.conn;
  assign out_stream_failed = res_r.failed;

  `AST_IMPL(a_bad_needs_done, clk, rst_n, valid_r && res_r.bad, res_r.done)
  `AST_IMPL(a_conn_only_ok, clk, rst_n, valid_r && res_r.conn != CONN_NONE,
            res_r.done && !res_r.bad)
  `AST_NEXT(a_bad_sticks, clk, rst_n, take && res.bad, failed_r)
endmodule
`default_nettype wire

/* verif/http_request_validator_test.sv */
// Testbench for http_request_validator: checks each result field against a predicted or given one
`timescale 1ns / 1ps
module http_request_validator_test;
  import hrv_pkg::*;

  typedef struct packed {
    phase_t     ph;
    logic [3:0] pos;
    logic [1:0] names;
    logic [2:0] vals;
    logic       cr_held;
    logic       gap_seen;
    logic       had_conn;
    logic       had_clen;
    logic [1:0] conn;
    logic       err;
    logic       dead;
  } parser_t;

  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    result_t    want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall, out_valid;
  logic [7:0] out_echo_byte;
  logic [1:0] out_byte_role, out_connection_kind;
  logic       out_message_done, out_request_bad, out_stream_failed;

  parser_t    parser;
  result_t    due_q[$];
  logic [7:0] msg_q[$];
  row_t       dir_rows[$];
  int         errors = 0;
  int         idle = 0;
  int         burst_left = 0;
  logic [8:0] stall_cnt = '0;

  http_request_validator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_echo_byte(out_echo_byte), .out_byte_role(out_byte_role),
    .out_message_done(out_message_done), .out_request_bad(out_request_bad),
    .out_connection_kind(out_connection_kind), .out_stream_failed(out_stream_failed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit differs(input string w, input logic [3:0] p, input logic [7:0] c);
    return p >= w.len() || w[p] != c;
  endfunction

  function automatic logic [3:0] advance(input logic [3:0] p);
    return (p == 4'd15) ? p : p + 4'd1;
  endfunction

  function automatic void restart(inout parser_t s);
    s.ph = PH_METHOD; s.pos = 0; s.names = 2'd3; s.vals = 3'd7;
    s.cr_held = 0; s.gap_seen = 0; s.had_conn = 0; s.had_clen = 0;
    s.conn = CONN_NONE; s.err = 0;
  endfunction

  function automatic void name_byte(inout parser_t s, input logic [7:0] c);
    logic [7:0] f;
    f = lower(c);
    if (!((f >= "a" && f <= "z") || (f >= "0" && f <= "9") || f == "_" || f == "-")) begin
      s.err = 1; s.ph = PH_SKIP; return;
    end
    if (differs("connection", s.pos, f)) s.names &= 2'd2;
    if (differs("content-length", s.pos, f)) s.names &= 2'd1;
    s.pos = advance(s.pos);
  endfunction

  function automatic void name_done(inout parser_t s);
    logic [1:0] kind;
    if (s.pos == 0) begin
      s.err = 1; s.ph = PH_SKIP; return;
    end
    if (s.names[0] && s.pos == 4'd10) kind = 2'd1;
    else if (s.names[1] && s.pos == 4'd14) kind = 2'd2;
    else begin
      s.ph = PH_SKIP; return;
    end
    if (kind == 2'd1) begin
      if (s.had_conn) s.err = 1;
      s.had_conn = 1;
    end else begin
      if (s.had_clen) s.err = 1;
      s.had_clen = 1;
    end
    s.names = kind; s.ph = PH_VALUE; s.pos = 0; s.gap_seen = 0;
    s.vals = (kind == 2'd1) ? 3'd3 : NUM_LEAD;
  endfunction

  function automatic void value_byte(inout parser_t s, input logic [7:0] c);
    logic [7:0] f;
    f = lower(c);
    if (s.names == 2'd1) begin
      if (f == CH_SP) begin
        if (s.pos > 0) s.gap_seen = 1;
        return;
      end
      if (s.gap_seen) begin
        s.vals = 0; return;
      end
      if (differs("close", s.pos, f)) s.vals &= 3'd2;
      if (differs("keep-alive", s.pos, f)) s.vals &= 3'd1;
      s.pos = advance(s.pos);
      return;
    end
    case (s.vals)
      NUM_LEAD: begin
        if (!(f == CH_SP || (f >= 8'd9 && f <= 8'd13))) begin
          if (f == "+" || f == "-") s.vals = NUM_SIGN;
          else s.vals = (f == "0") ? NUM_ZEROS : NUM_BAD;
        end
      end
      NUM_SIGN: s.vals = (f == "0") ? NUM_ZEROS : NUM_BAD;
      NUM_ZEROS: begin
        if (f == CH_SP) s.vals = NUM_TRAIL;
        else if (f != "0") s.vals = NUM_BAD;
      end
      NUM_TRAIL: if (f != CH_SP) s.vals = NUM_BAD;
      default: s.vals = NUM_BAD;
    endcase
  endfunction

  function automatic void line_text(inout parser_t s, input logic [7:0] c);
    case (s.ph)
      PH_METHOD: if (c == CH_SP) s.ph = PH_TARGET_FIRST;
      PH_TARGET_FIRST: begin
        if (c == CH_SP) begin
          s.err = 1; s.ph = PH_VERSION; s.pos = 0;
        end else begin
          if (c != "/") s.err = 1;
          s.ph = PH_TARGET;
        end
      end
      PH_TARGET: if (c == CH_SP) begin
        s.ph = PH_VERSION; s.pos = 0;
      end
      PH_VERSION: begin
        if (differs("HTTP/1.1", s.pos, c)) s.err = 1;
        s.pos = advance(s.pos);
      end
      PH_LINE_START, PH_NAME: begin
        if (s.ph == PH_LINE_START) begin
          s.ph = PH_NAME; s.names = 2'd3; s.pos = 0;
        end
        if (c == ":") name_done(s);
        else name_byte(s, c);
      end
      PH_VALUE: value_byte(s, c);
      default: ;
    endcase
  endfunction

  function automatic bit line_close(inout parser_t s);
    case (s.ph)
      PH_LINE_START: return 1;
      PH_VERSION: if (s.pos != 4'd8) s.err = 1;
      PH_VALUE: begin
        if (s.names == 2'd1) begin
          if (s.vals[0] && s.pos == 4'd5) s.conn = CONN_CLOSE;
          else if (s.vals[1] && s.pos == 4'd10) s.conn = CONN_KEEP;
          else s.err = 1;
        end else if (s.vals != NUM_ZEROS && s.vals != NUM_TRAIL) begin
          s.err = 1;
        end
      end
      PH_SKIP: ;
      default: s.err = 1;
    endcase
    s.ph = PH_LINE_START;
    return 0;
  endfunction

  function automatic result_t parse_byte(inout parser_t s, input logic [7:0] c);
    result_t r;
    r = '0;
    r.echo = c;
    r.role = ROLE_TEXT;
    r.failed = s.dead;
    if (s.dead) return r;
    if (s.cr_held) begin
      if (c == CH_LF) begin
        s.cr_held = 0;
        r.role = ROLE_BREAK;
        if (line_close(s)) begin
          r.done = 1;
          r.bad = s.err;
          r.conn = s.err ? CONN_NONE : s.conn;
          if (s.err) s.dead = 1;
          restart(s);
        end
        return r;
      end
      line_text(s, CH_CR);
      if (c == CH_CR) begin
        r.role = ROLE_BREAK;
        return r;
      end
      s.cr_held = 0;
    end
    if (c == CH_CR) begin
      s.cr_held = 1;
      r.role = ROLE_BREAK;
      return r;
    end
    if (s.ph == PH_METHOD) r.role = ROLE_METHOD;
    else if (s.ph == PH_TARGET_FIRST || s.ph == PH_TARGET) r.role = ROLE_TARGET;
    line_text(s, c);
    return r;
  endfunction

  function automatic row_t row(input logic [7:0] c, input logic typed,
                               input logic [1:0] role, input logic done);
    row_t t;
    t.c = c;
    t.typed = typed;
    t.want = '0;
    t.want.echo = c;
    t.want.role = role;
    t.want.done = done;
    return t;
  endfunction

  task automatic put(input logic [7:0] c, input logic typed, input result_t want);
    result_t got;
    in_valid <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = parse_byte(parser, c);
    due_q.insert(due_q.size(), typed ? want : got);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) add_byte(t[i]);
  endtask

  task automatic add_cased(input string t);
    for (int i = 0; i < t.len(); i++)
      add_byte(($urandom_range(0, 1) && t[i] >= "a" && t[i] <= "z") ? t[i] - 8'd32 : t[i]);
  endtask

  task automatic add_spaces(input int hi);
    repeat ($urandom_range(0, hi)) add_byte(CH_SP);
  endtask

  task automatic build_request();
    string      pool;
    logic [7:0] c;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
    msg_q.delete();
    repeat ($urandom_range(1, 6)) begin
      c = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(65, 90));
      if (c == CH_SP || c == CH_CR) c = "M";
      add_byte(c);
      if ($urandom_range(0, 14) == 0) add_text("\rM");
    end
    add_text(" /");
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      add_byte((c == CH_SP || c == CH_CR) ? 8'h7e : c);
    end
    add_text(" HTTP/1.1\r\n");
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: begin
          add_cased("connection:");
          add_spaces(2);
          add_cased($urandom_range(0, 1) ? "close" : "keep-alive");
          add_spaces(2);
        end
        1: begin
          add_cased("content-length:");
          repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SP : 8'h09);
          case ($urandom_range(0, 2))
            0: add_text("+");
            1: add_text("-");
            default: ;
          endcase
          repeat ($urandom_range(1, 3)) add_text("0");
          add_spaces(2);
        end
        default: begin
          repeat ($urandom_range(1, 8)) add_byte(pool[$urandom_range(0, pool.len() - 1)]);
          add_text(":");
          repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(0, 255));
            add_byte(c == CH_CR ? 8'h00 : c);
          end
          if ($urandom_range(0, 5) == 0) add_text("\r\rq");
        end
      endcase
      add_text("\r\n");
    end
    add_text("\r\n");
  endtask

  task automatic chk(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1'b1;
    case (stall_cnt[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_cnt[3:0] < 4'd10);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual echo %0h", $time, out_echo_byte);
        errors++;
      end else begin
        chk("echo_byte", int'(due_q[0].echo), int'(out_echo_byte));
        chk("byte_role", int'(due_q[0].role), int'(out_byte_role));
        chk("message_done", int'(due_q[0].done), int'(out_message_done));
        chk("request_bad", int'(due_q[0].bad), int'(out_request_bad));
        chk("connection_kind", int'(due_q[0].conn), int'(out_connection_kind));
        chk("stream_failed", int'(due_q[0].failed), int'(out_stream_failed));
        void'(due_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= 3000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    parser_t probe;
    result_t r;
    int      sent;
    bit      rejected;
    parser = '0;
    restart(parser);
    dir_rows = {
      row(8'h00, 1'b1, ROLE_METHOD, 1'b0), row(8'hff, 1'b1, ROLE_METHOD, 1'b0),
      row(" ", 1'b0, ROLE_METHOD, 1'b0), row("/", 1'b0, ROLE_METHOD, 1'b0),
      row(" ", 1'b0, ROLE_METHOD, 1'b0), row("H", 1'b0, ROLE_METHOD, 1'b0),
      row("T", 1'b0, ROLE_METHOD, 1'b0), row("T", 1'b0, ROLE_METHOD, 1'b0),
      row("P", 1'b0, ROLE_METHOD, 1'b0), row("/", 1'b0, ROLE_METHOD, 1'b0),
      row("1", 1'b0, ROLE_METHOD, 1'b0), row(".", 1'b0, ROLE_METHOD, 1'b0),
      row("1", 1'b0, ROLE_METHOD, 1'b0), row(CH_CR, 1'b1, ROLE_BREAK, 1'b0),
      row(CH_LF, 1'b1, ROLE_BREAK, 1'b0), row(CH_CR, 1'b1, ROLE_BREAK, 1'b0),
      row(CH_LF, 1'b1, ROLE_BREAK, 1'b1)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) put(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);

    sent = 0;
    while (sent < 900) begin
      do begin
        build_request();
        probe = parser;
        rejected = 0;
        foreach (msg_q[i]) begin
          r = parse_byte(probe, msg_q[i]);
          if (r.done && r.bad) rejected = 1;
        end
      end while (rejected);
      foreach (msg_q[i]) put(msg_q[i], 0, '0);
      sent += msg_q.size();
    end

    // drop the stream: one rejected request, then bytes that are only echoed
    msg_q.delete();
    if ($urandom_range(0, 1)) begin
      add_text("\r\nAb");
      add_byte(8'hc3);
      add_text(":1\r\n:v\r\nConnection: close\r\nconnection: close\r\n");
      add_text("Content-Length: 1\r\nno\nname: x\r\n\r\n");
    end else begin
      add_text("GET  HTTP/1.0\r\nConnection: maybe\r\nhost\r\n\r\n");
    end
    repeat (40) add_byte(8'($urandom_range(0, 255)));
    foreach (msg_q[i]) put(msg_q[i], 0, '0);
    in_valid <= 1'b0;

    while (due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
